@@ rtl/lcdnw_pkg.sv @@
// Shared types and constants for the character LCD nibble write sequencer.
`default_nettype none

package lcdnw_pkg;

    // Default width of the phase tick counter.
    localparam int TICK_COUNT_BITS_DEFAULT = 8;

    // Width of the timing registers and of the configuration data.
    localparam int CFG_DATA_W  = 8;
    localparam int CFG_INDEX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_SETUP = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PULSE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_HOLD  = 2'd2;

    // Reset values of the timing registers.
    localparam logic [CFG_DATA_W-1:0] SETUP_RESET = 8'd1;
    localparam logic [CFG_DATA_W-1:0] PULSE_RESET = 8'd1;
    localparam logic [CFG_DATA_W-1:0] HOLD_RESET  = 8'd5;

    // Command codes on the input channel.
    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_NIBBLE = 2'd1;
    localparam logic [1:0] CMD_BYTE   = 2'd2;

    // Depth of the queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;

    // Class of a decoded transaction.
    typedef enum logic [1:0] {
        KIND_IGNORE,
        KIND_TICK,
        KIND_NIBBLE,
        KIND_BYTE
    } t_kind;

    // Decoded transaction as it travels through the queue.
    typedef struct packed {
        t_kind      kind;
        logic       rs;
        logic [3:0] hi;
        logic [3:0] lo;
    } t_item;

    // One result transaction: the bus lines and status after an item.
    typedef struct packed {
        logic       pin_rs;
        logic       pin_rw;
        logic       pin_enable;
        logic [3:0] pin_data;
        logic       busy_res;
        logic       rejected;
    } t_result;

endpackage

`default_nettype wire

@@ rtl/lcdnw_front.sv @@
// Front part: accepts input transactions, classifies them and registers the result.
`default_nettype none

module lcdnw_front
    import lcdnw_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [1:0] i_command,
    input  wire logic       i_register_select,
    input  wire logic [7:0] i_byte_value,
    output logic            o_item_valid,
    input  wire logic       i_item_ready,
    output t_item           o_item
);

    logic  r_valid;
    t_item r_item;
    t_item n_item;

    // Classify the command and split the byte into its two nibbles.
    always_comb begin
        n_item.rs = i_register_select;
        n_item.hi = 4'd0;
        n_item.lo = 4'd0;
        case (i_command)
            CMD_TICK: begin
                n_item.kind = KIND_TICK;
            end
            CMD_NIBBLE: begin
                n_item.kind = KIND_NIBBLE;
                n_item.hi   = i_byte_value[3:0];
            end
            CMD_BYTE: begin
                n_item.kind = KIND_BYTE;
                n_item.hi   = i_byte_value[7:4];
                n_item.lo   = i_byte_value[3:0];
            end
            default: begin
                n_item.kind = KIND_IGNORE;
            end
        endcase
    end

    // The stage takes a new transaction whenever it is empty or being drained.
    assign o_ready      = !r_valid || i_item_ready;
    assign o_item_valid = r_valid;
    assign o_item       = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

`default_nettype wire

@@ rtl/lcdnw_queue.sv @@
// Short queue of decoded transactions between the front and back parts.
`default_nettype none

module lcdnw_queue
    import lcdnw_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push_valid,
    output logic       o_push_ready,
    input  wire t_item i_push_item,
    output logic       o_pop_valid,
    input  wire logic  i_pop_ready,
    output t_item      o_pop_item
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    t_item            r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;
    logic             push;
    logic             pop;

    assign o_push_ready = (r_count != FULL_CNT);
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_item   = r_mem[r_rptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // Storage write.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_push_item;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= (r_wptr == LAST_PTR) ? '0 : r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= (r_rptr == LAST_PTR) ? '0 : r_rptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/lcdnw_back.sv @@
// Back part: runs the nibble phase sequencer and holds the result register.
`default_nettype none

module lcdnw_back
    import lcdnw_pkg::*;
#(
    parameter int TICK_COUNT_BITS = TICK_COUNT_BITS_DEFAULT
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                   i_item_valid,
    output logic                        o_item_ready,
    input  wire t_item                  i_item,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output t_result                     o_result
);

    localparam int LW = (TICK_COUNT_BITS > CFG_DATA_W) ? TICK_COUNT_BITS : CFG_DATA_W;
    localparam logic [LW-1:0] CNT_MAX = LW'({TICK_COUNT_BITS{1'b1}});

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_SETUP,
        PH_PULSE,
        PH_HOLD
    } t_phase;

    // Phase length: zero counts as one, lengths beyond the counter saturate.
    function automatic logic [TICK_COUNT_BITS-1:0] load_len(input logic [CFG_DATA_W-1:0] v);
        logic [LW-1:0] w;
        w = LW'(v);
        if (w == '0) begin
            w = LW'(1);
        end
        if (w > CNT_MAX) begin
            w = CNT_MAX;
        end
        return w[TICK_COUNT_BITS-1:0];
    endfunction

    logic [CFG_DATA_W-1:0]      r_setup;
    logic [CFG_DATA_W-1:0]      r_pulse;
    logic [CFG_DATA_W-1:0]      r_hold;

    t_phase                     r_phase, n_phase;
    logic [TICK_COUNT_BITS-1:0] r_left, n_left;
    logic                       r_pend, n_pend;
    logic [3:0]                 r_saved, n_saved;
    logic                       r_rs, n_rs;
    logic                       r_en, n_en;
    logic [3:0]                 r_data, n_data;

    logic                       r_out_valid;
    t_result                    r_out;

    logic                       pop;
    logic                       busy;
    logic                       rej;
    logic                       do_adv;

    // The back part takes an item whenever the result register is free.
    assign o_item_ready = !r_out_valid || i_ready;
    assign pop          = i_item_valid && o_item_ready;
    assign busy         = (r_phase != PH_IDLE);

    // Next sequencer state for the item at the head of the queue.
    always_comb begin
        n_phase = r_phase;
        n_left  = r_left;
        n_pend  = r_pend;
        n_saved = r_saved;
        n_rs    = r_rs;
        n_en    = r_en;
        n_data  = r_data;
        rej     = 1'b0;
        do_adv  = 1'b0;
        if (pop) begin
            case (i_item.kind)
                KIND_TICK: begin
                    if (busy) begin
                        if (r_left != '0) begin
                            n_left = r_left - 1'b1;
                        end
                        do_adv = (n_left == '0);
                    end
                end
                KIND_NIBBLE, KIND_BYTE: begin
                    if (busy) begin
                        rej = 1'b1;
                    end else begin
                        n_rs    = i_item.rs;
                        n_data  = i_item.hi;
                        n_saved = i_item.lo;
                        n_pend  = (i_item.kind == KIND_BYTE);
                        n_phase = PH_SETUP;
                        n_en    = 1'b0;
                        n_left  = load_len(r_setup);
                    end
                end
                default: begin
                end
            endcase
        end
        // Phase change when the tick count runs out.
        if (do_adv) begin
            case (r_phase)
                PH_SETUP: begin
                    n_phase = PH_PULSE;
                    n_en    = 1'b1;
                    n_left  = load_len(r_pulse);
                end
                PH_PULSE: begin
                    n_phase = PH_HOLD;
                    n_en    = 1'b0;
                    n_left  = load_len(r_hold);
                end
                PH_HOLD: begin
                    if (r_pend) begin
                        n_pend  = 1'b0;
                        n_data  = r_saved;
                        n_phase = PH_SETUP;
                        n_en    = 1'b0;
                        n_left  = load_len(r_setup);
                    end else begin
                        n_phase = PH_IDLE;
                        n_en    = 1'b0;
                        n_data  = 4'd0;
                        n_rs    = 1'b0;
                        n_left  = '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Timing registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setup <= SETUP_RESET;
            r_pulse <= PULSE_RESET;
            r_hold  <= HOLD_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SETUP: r_setup <= i_cfg_data;
                CFG_PULSE: r_pulse <= i_cfg_data;
                CFG_HOLD:  r_hold  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Sequencer state and the registered result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_left      <= '0;
            r_pend      <= 1'b0;
            r_saved     <= 4'd0;
            r_rs        <= 1'b0;
            r_en        <= 1'b0;
            r_data      <= 4'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_left  <= n_left;
            r_pend  <= n_pend;
            r_saved <= n_saved;
            r_rs    <= n_rs;
            r_en    <= n_en;
            r_data  <= n_data;
            if (o_item_ready) begin
                r_out_valid <= i_item_valid;
            end
        end
        if (pop) begin
            r_out.pin_rs     <= n_rs;
            r_out.pin_rw     <= 1'b0;
            r_out.pin_enable <= n_en;
            r_out.pin_data   <= n_data;
            r_out.busy_res   <= (n_phase != PH_IDLE);
            r_out.rejected   <= rej;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

`default_nettype wire

@@ rtl/char_lcd_nibble_write_sequencer.sv @@
// Top level of the character LCD 4-bit bus write sequencer.
//
// Input channel (i_valid / o_ready): one transaction is a tick, a lone nibble
// request or a byte request with a register select flag. Output channel
// (o_valid / i_ready): exactly one result transaction per input transaction,
// in order, showing the RS, RW, E and D7..D4 levels, busy and rejected.
// Timing registers (setup, pulse, hold, in ticks) are written through i_cfg_we /
// i_cfg_index / i_cfg_data by the user only while the block is idle (not enforced).
//
// From input acceptance to the result being offered, a transaction passes
// the classifying register in the front part, the two-entry queue and the
// result register of the back part, in that order. Throughput is one
// transaction per cycle while the receiver does not stall; the back part
// updates the sequencer once for every item it pops.
//
// A synchronous reset on i_rst_n clears the sequencer to idle with all bus
// lines low and restores the timing registers to 1, 1 and 5. When the
// receiver stalls, the result register holds its transaction, the queue
// fills, and o_ready drops once the front register is also occupied.
`default_nettype none

module char_lcd_nibble_write_sequencer
    import lcdnw_pkg::*;
#(
    parameter int TICK_COUNT_BITS = TICK_COUNT_BITS_DEFAULT
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire logic [1:0]             i_command,
    input  wire logic                   i_register_select,
    input  wire logic [7:0]             i_byte_value,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic                        o_pin_rs,
    output logic                        o_pin_rw,
    output logic                        o_pin_enable,
    output logic [3:0]                  o_pin_data,
    output logic                        o_busy_res,
    output logic                        o_rejected
);

    logic    front_valid;
    logic    front_ready;
    t_item   front_item;
    logic    queue_valid;
    logic    queue_ready;
    t_item   queue_item;
    t_result result;

    lcdnw_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_command         (i_command),
        .i_register_select (i_register_select),
        .i_byte_value      (i_byte_value),
        .o_item_valid      (front_valid),
        .i_item_ready      (front_ready),
        .o_item            (front_item)
    );

    lcdnw_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .i_push_item  (front_item),
        .o_pop_valid  (queue_valid),
        .i_pop_ready  (queue_ready),
        .o_pop_item   (queue_item)
    );

    lcdnw_back #(
        .TICK_COUNT_BITS (TICK_COUNT_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_item_valid (queue_valid),
        .o_item_ready (queue_ready),
        .i_item       (queue_item),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_result     (result)
    );

    assign o_pin_rs     = result.pin_rs;
    assign o_pin_rw     = result.pin_rw;
    assign o_pin_enable = result.pin_enable;
    assign o_pin_data   = result.pin_data;
    assign o_busy_res   = result.busy_res;
    assign o_rejected   = result.rejected;

endmodule

`default_nettype wire

@@ rtl/lcdnw_checker.sv @@
// Port-level assertions for the sequencer and the bind that attaches them.
`default_nettype none

module lcdnw_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_valid,
    input wire logic       i_ready,
    input wire logic       o_pin_rs,
    input wire logic       o_pin_rw,
    input wire logic       o_pin_enable,
    input wire logic [3:0] o_pin_data,
    input wire logic       o_busy_res,
    input wire logic       o_rejected
);

    // When the transfer is over, all bus lines are back at 0.
    a_idle_lines_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_busy_res) |-> (!o_pin_rs && !o_pin_enable && o_pin_data == 4'd0))
        else $error("bus lines not cleared while idle");

    // The enable strobe is only high during a transfer.
    a_enable_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_pin_enable) |-> o_busy_res)
        else $error("enable high while not busy");

    // A request is only rejected while a transfer is running, and the display is never read.
    a_reject_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((!o_rejected || o_busy_res) && !o_pin_rw))
        else $error("rejection without transfer or read strobe seen");

    // A stalled result transaction holds its payload.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_pin_data) && $stable(o_pin_enable)
                                   && $stable(o_busy_res) && $stable(o_rejected)))
        else $error("result changed while stalled");

endmodule

bind char_lcd_nibble_write_sequencer lcdnw_checker u_lcdnw_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_pin_rs     (o_pin_rs),
    .o_pin_rw     (o_pin_rw),
    .o_pin_enable (o_pin_enable),
    .o_pin_data   (o_pin_data),
    .o_busy_res   (o_busy_res),
    .o_rejected   (o_rejected)
);

`default_nettype wire

@@ tb/tb_char_lcd_nibble_write_sequencer.sv @@
// Self-checking testbench for the character LCD 4-bit bus write sequencer.
`timescale 1ns / 1ps

module tb_char_lcd_nibble_write_sequencer;
    import lcdnw_pkg::*;

    // Command code that the block decodes as nothing.
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    // Register index that selects no register.
    localparam logic [CFG_INDEX_W-1:0] CFG_NONE = 2'd3;

    // Bus sequencing phases of the local predictor.
    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_SETUP,
        SEQ_PULSE,
        SEQ_HOLD
    } seq_phase_t;

    // One input transaction waiting to be driven.
    typedef struct {
        logic [1:0] cmd;
        logic       rs;
        logic [7:0] val;
    } lcd_req_t;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic                   i_valid;
    logic                   o_ready;
    logic [1:0]             i_command;
    logic                   i_register_select;
    logic [7:0]             i_byte_value;
    logic                   o_valid;
    logic                   i_ready;
    logic                   o_pin_rs;
    logic                   o_pin_rw;
    logic                   o_pin_enable;
    logic [3:0]             o_pin_data;
    logic                   o_busy_res;
    logic                   o_rejected;

    char_lcd_nibble_write_sequencer u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_command         (i_command),
        .i_register_select (i_register_select),
        .i_byte_value      (i_byte_value),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_pin_rs          (o_pin_rs),
        .o_pin_rw          (o_pin_rw),
        .o_pin_enable      (o_pin_enable),
        .o_pin_data        (o_pin_data),
        .o_busy_res        (o_busy_res),
        .o_rejected        (o_rejected)
    );

    // Shadow timing registers and sequencer state.
    logic [7:0] setup_cfg;
    logic [7:0] pulse_cfg;
    logic [7:0] hold_cfg;
    seq_phase_t seq_phase;
    logic [7:0] ticks_left;
    logic       low_pending;
    logic [3:0] low_saved;
    logic       rs_level;
    logic       en_level;
    logic [3:0] data_level;

    // Stimulus, expectations and bookkeeping.
    lcd_req_t pending_req_q[$];
    t_result  expected_bus_q[$];
    lcd_req_t cur_req;
    bit       have_item;
    bit       took_item;
    bit       idle_on;
    int       gap_left;
    int       stall_left;
    int       err_count;
    int       results_checked;
    int       xfers_started;
    int       refusals;
    int       settings_used;

    // Clock generation.
    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // A programmed phase length of zero behaves as one tick.
    function automatic logic [7:0] phase_len(logic [7:0] r);
        return (r == 8'd0) ? 8'd1 : r;
    endfunction

    function automatic int nibble_ticks();
        return int'(phase_len(setup_cfg)) + int'(phase_len(pulse_cfg))
            + int'(phase_len(hold_cfg));
    endfunction

    // Enter a phase and load its tick count from the timing registers.
    task automatic load_phase(seq_phase_t p);
        seq_phase = p;
        case (p)
            SEQ_SETUP: begin
                en_level   = 1'b0;
                ticks_left = phase_len(setup_cfg);
            end
            SEQ_PULSE: begin
                en_level   = 1'b1;
                ticks_left = phase_len(pulse_cfg);
            end
            SEQ_HOLD: begin
                en_level   = 1'b0;
                ticks_left = phase_len(hold_cfg);
            end
            default: begin
                en_level   = 1'b0;
                data_level = 4'h0;
                rs_level   = 1'b0;
                ticks_left = 8'd0;
            end
        endcase
    endtask

    // Move on once the current phase has used up its ticks.
    task automatic next_phase();
        case (seq_phase)
            SEQ_SETUP: load_phase(SEQ_PULSE);
            SEQ_PULSE: load_phase(SEQ_HOLD);
            SEQ_HOLD: begin
                if (low_pending) begin
                    low_pending = 1'b0;
                    data_level  = low_saved;
                    load_phase(SEQ_SETUP);
                end else begin
                    load_phase(SEQ_IDLE);
                end
            end
            default: ;
        endcase
    endtask

    // Apply one accepted transaction and queue the bus levels it leaves.
    task automatic predict_bus_levels(logic [1:0] cmd, logic rs, logic [7:0] val);
        t_result r;
        logic    refused;
        refused = 1'b0;
        case (cmd)
            CMD_TICK: begin
                if (seq_phase != SEQ_IDLE) begin
                    if (ticks_left > 0) ticks_left = ticks_left - 8'd1;
                    if (ticks_left == 0) next_phase();
                end
            end
            CMD_NIBBLE, CMD_BYTE: begin
                if (seq_phase != SEQ_IDLE) begin
                    refused = 1'b1;
                    refusals++;
                end else begin
                    rs_level = rs;
                    if (cmd == CMD_BYTE) begin
                        data_level  = val[7:4];
                        low_saved   = val[3:0];
                        low_pending = 1'b1;
                    end else begin
                        data_level  = val[3:0];
                        low_saved   = 4'h0;
                        low_pending = 1'b0;
                    end
                    load_phase(SEQ_SETUP);
                    xfers_started++;
                end
            end
            default: ;
        endcase
        r.pin_rs     = rs_level;
        r.pin_rw     = 1'b0;
        r.pin_enable = en_level;
        r.pin_data   = data_level;
        r.busy_res   = (seq_phase != SEQ_IDLE);
        r.rejected   = refused;
        expected_bus_q.push_back(r);
    endtask

    task automatic check_field(string name, logic [3:0] exp_v, logic [3:0] act_v);
        if (act_v !== exp_v) begin
            err_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, name, exp_v, act_v);
        end
    endtask

    // Input acceptance feeds the predictor; output acceptance is checked.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_bus_q.size() == 0) begin
                err_count++;
                $display("%0t: result transaction with nothing expected", $time);
            end else begin
                want = expected_bus_q.pop_front();
                results_checked++;
                check_field("pin_rs", want.pin_rs, o_pin_rs);
                check_field("pin_rw", want.pin_rw, o_pin_rw);
                check_field("pin_enable", want.pin_enable, o_pin_enable);
                check_field("pin_data", want.pin_data, o_pin_data);
                check_field("busy_res", want.busy_res, o_busy_res);
                check_field("rejected", want.rejected, o_rejected);
            end
        end
        if (i_rst_n && i_valid && o_ready) begin
            predict_bus_levels(i_command, i_register_select, i_byte_value);
            took_item = 1'b1;
        end
    end

    // Driver: presents queued transactions with random gaps between them.
    always @(negedge i_clk) begin
        if (took_item) begin
            took_item = 1'b0;
            have_item = 1'b0;
            if (idle_on && $urandom_range(0, 4) == 0) gap_left = $urandom_range(1, 7);
        end
        if (!have_item) begin
            if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (pending_req_q.size() > 0) begin
                cur_req = pending_req_q.pop_front();
                i_valid           <= 1'b1;
                i_command         <= cur_req.cmd;
                i_register_select <= cur_req.rs;
                i_byte_value      <= cur_req.val;
                have_item = 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver: stalls the result channel in random bursts.
    always @(negedge i_clk) begin
        if (!idle_on) begin
            i_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 6);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    function automatic void push_req(logic [1:0] cmd, logic rs, logic [7:0] val);
        lcd_req_t t;
        t.cmd = cmd;
        t.rs  = rs;
        t.val = val;
        pending_req_q.push_back(t);
    endfunction

    function automatic void push_tick();
        push_req(CMD_TICK, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
    endfunction

    // Queue one send request followed by the ticks that should finish it,
    // sprinkled with refused requests and unused commands. Returns the
    // number of transactions queued before the closing idle ticks.
    function automatic int queue_transfer(bit as_byte, bit may_cut);
        int span;
        int cnt;
        int k;
        span = as_byte ? 2 * nibble_ticks() : nibble_ticks();
        // Occasionally stop short so the next request finds the block busy.
        if (may_cut && $urandom_range(0, 9) == 0) span = $urandom_range(0, span - 1);
        push_req(as_byte ? CMD_BYTE : CMD_NIBBLE, 1'($urandom_range(0, 1)),
                 8'($urandom_range(0, 255)));
        cnt = 1;
        for (k = 0; k < span; k++) begin
            if ($urandom_range(0, 11) == 0) begin
                case ($urandom_range(0, 2))
                    0: push_req(CMD_NIBBLE, 1'($urandom_range(0, 1)),
                                8'($urandom_range(0, 255)));
                    1: push_req(CMD_BYTE, 1'($urandom_range(0, 1)),
                                8'($urandom_range(0, 255)));
                    default: push_req(CMD_UNUSED, 1'($urandom_range(0, 1)),
                                      8'($urandom_range(0, 255)));
                endcase
                cnt++;
            end
            push_tick();
            cnt++;
        end
        // A few ticks while idle.
        repeat ($urandom_range(0, 2)) push_tick();
        return cnt;
    endfunction

    // Fill one random phase, then tick long enough to leave the block idle.
    task automatic queue_random_phase(int target);
        int n;
        n = 0;
        while (n < target) n += queue_transfer(1'($urandom_range(0, 1)), 1'b1);
        repeat (2 * nibble_ticks()) push_tick();
    endtask

    // Register write at a quiet point; the shadow follows the same edge.
    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_SETUP: setup_cfg = val;
            CFG_PULSE: pulse_cfg = val;
            CFG_HOLD:  hold_cfg  = val;
            default: ;
        endcase
    endtask

    task automatic write_timing(logic [7:0] s, logic [7:0] p, logic [7:0] h);
        write_reg(CFG_SETUP, s);
        write_reg(CFG_PULSE, p);
        write_reg(CFG_HOLD, h);
        settings_used++;
    endtask

    // Hold the sender until every queued transaction has its result back.
    task automatic wait_drained();
        do @(posedge i_clk);
        while (pending_req_q.size() != 0 || have_item || expected_bus_q.size() != 0);
    endtask

    // Main sequence: reset, directed checks, then random phases.
    initial begin
        int ph;
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_index       = CFG_SETUP;
        i_cfg_data        = 8'h00;
        i_valid           = 1'b0;
        i_command         = CMD_TICK;
        i_register_select = 1'b0;
        i_byte_value      = 8'h00;
        i_ready           = 1'b0;
        setup_cfg   = SETUP_RESET;
        pulse_cfg   = PULSE_RESET;
        hold_cfg    = HOLD_RESET;
        seq_phase   = SEQ_IDLE;
        ticks_left  = 8'd0;
        low_pending = 1'b0;
        low_saved   = 4'h0;
        rs_level    = 1'b0;
        en_level    = 1'b0;
        data_level  = 4'h0;
        have_item   = 1'b0;
        took_item   = 1'b0;
        idle_on     = 1'b1;
        gap_left    = 0;
        stall_left  = 0;
        err_count   = 0;
        results_checked = 0;
        xfers_started   = 0;
        refusals        = 0;
        settings_used   = 1;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset timing: idle tick, unused command, a function-set nibble,
        // a byte refused while busy, then exactly the ticks to finish.
        push_req(CMD_TICK, 1'b1, 8'hFF);
        push_req(CMD_UNUSED, 1'b1, 8'hFF);
        push_req(CMD_NIBBLE, 1'b0, 8'h02);
        push_req(CMD_BYTE, 1'b1, 8'hA5);
        repeat (7) push_req(CMD_TICK, 1'b0, 8'h00);
        wait_drained();

        // Zero phase lengths behave as one tick; an unknown index is ignored.
        write_timing(8'd0, 8'd0, 8'd0);
        write_reg(CFG_NONE, 8'hFF);
        push_req(CMD_BYTE, 1'b1, 8'hFF);
        push_req(CMD_NIBBLE, 1'b0, 8'h0F);
        push_req(CMD_UNUSED, 1'b0, 8'h00);
        repeat (6) push_req(CMD_TICK, 1'b1, 8'h00);
        push_req(CMD_BYTE, 1'b0, 8'h00);
        repeat (6) push_req(CMD_TICK, 1'b0, 8'hFF);
        wait_drained();

        // Random phases over a spread of timing settings.
        for (ph = 0; ph < 6; ph++) begin
            case (ph)
                0: write_timing(SETUP_RESET, PULSE_RESET, HOLD_RESET);
                1: write_timing(8'd1, 8'd1, 8'd1);
                2: write_timing(8'($urandom_range(1, 4)), 8'($urandom_range(1, 4)),
                                8'($urandom_range(1, 4)));
                3: write_timing(8'($urandom_range(1, 12)), 8'($urandom_range(1, 12)),
                                8'($urandom_range(1, 12)));
                4: write_timing(8'($urandom_range(0, 2)), 8'($urandom_range(0, 2)),
                                8'($urandom_range(0, 2)));
                default: write_timing(8'($urandom_range(1, 3)), 8'($urandom_range(1, 3)),
                                      8'($urandom_range(1, 3)));
            endcase
            // No idling in one stretch in the middle and in the one at the end.
            idle_on = (ph != 3) && (ph != 5);
            queue_random_phase(75);
            wait_drained();

            // Full-scale pulse length once, on a single lone nibble.
            if (ph == 2) begin
                write_timing(8'd1, 8'd255, 8'd1);
                void'(queue_transfer(1'b0, 1'b0));
                wait_drained();
            end
        end

        repeat (8) @(posedge i_clk);
        $display("Checked %0d result transactions: %0d transfers started, %0d requests",
                 results_checked, xfers_started, refusals);
        $display("refused while busy, across %0d timing settings from zero to full scale.",
                 settings_used);
        if (err_count == 0 && expected_bus_q.size() == 0) begin
            $display("tb_char_lcd_nibble_write_sequencer: PASS");
        end else begin
            $display("tb_char_lcd_nibble_write_sequencer: FAIL");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #5ms;
        $display("Timeout with %0d results outstanding.", expected_bus_q.size());
        $display("tb_char_lcd_nibble_write_sequencer: FAIL");
        $finish;
    end

endmodule
